### rtl/a64pcr_pkg.sv
`timescale 1ns / 1ps

package a64pcr_pkg;

    localparam int WordW = 32;
    localparam int AddrW = 64;
    localparam int PageW = 52;
    localparam int ClsW  = 4;
    localparam int IdxW  = 3;

    typedef enum logic [ClsW-1:0] {
        ClsOther = 4'd0,
        ClsBl    = 4'd1,
        ClsB     = 4'd2,
        ClsBcond = 4'd3,
        ClsCbz   = 4'd4,
        ClsTbz   = 4'd5,
        ClsAdr   = 4'd6,
        ClsAdrp  = 4'd7,
        ClsLit   = 4'd8
    } t_cls;

    // opcode masks and match values
    localparam logic [WordW-1:0] MaskBr    = 32'hfc000000;
    localparam logic [WordW-1:0] OpBl      = 32'h94000000;
    localparam logic [WordW-1:0] OpB       = 32'h14000000;
    localparam logic [WordW-1:0] MaskBcond = 32'hff000010;
    localparam logic [WordW-1:0] OpBcond   = 32'h54000000;
    localparam logic [WordW-1:0] MaskCb    = 32'h7e000000;
    localparam logic [WordW-1:0] OpCbz     = 32'h34000000;
    localparam logic [WordW-1:0] OpTbz     = 32'h36000000;
    localparam logic [WordW-1:0] MaskAdr   = 32'h9f000000;
    localparam logic [WordW-1:0] OpAdr     = 32'h10000000;
    localparam logic [WordW-1:0] OpAdrp    = 32'h90000000;
    localparam logic [WordW-1:0] MaskLit   = 32'h3b000000;
    localparam logic [WordW-1:0] OpLit     = 32'h18000000;

    // re-encode keep masks
    localparam logic [WordW-1:0] KeepImm19 = 32'hff00001f;
    localparam logic [WordW-1:0] KeepImm14 = 32'hfff8001f;
    localparam logic [WordW-1:0] KeepAdr   = 32'h9f00001f;

    // expansion words
    localparam logic [WordW-1:0] MovzHw0 = 32'hd2800000;
    localparam logic [WordW-1:0] MovkHw1 = 32'hf2a00000;
    localparam logic [WordW-1:0] MovkHw2 = 32'hf2c00000;
    localparam logic [WordW-1:0] MovkHw3 = 32'hf2e00000;
    localparam logic [WordW-1:0] BlrX17  = 32'hd63f0220;
    localparam logic [WordW-1:0] BrX17   = 32'hd61f0220;
    localparam logic [4:0]       ScratchReg = 5'd17;

    localparam logic [IdxW-1:0] LastOne  = 3'd0;
    localparam logic [IdxW-1:0] LastMov4 = 3'd3;
    localparam logic [IdxW-1:0] LastBr5  = 3'd4;

endpackage

### rtl/aarch64_pc_relative_relocator_core.sv
`timescale 1ns / 1ps

// AArch64 PC-relative instruction relocator.
//
// Request channel: drive i_instr_word, i_source_pc and i_dest_pc with
// i_start high; the request is taken at a rising edge where o_busy is low.
// Result channel: each emitted word appears on o_out_word with o_last_word,
// o_range_fail and o_instr_class for exactly one cycle while o_valid is
// high. The receiver cannot stall; it must take every strobed word.
//
// The first word of a request passes the input register, then the result
// register, before it is strobed.
// Throughput: one request per cycle for single-word results. B and BL expand
// to five words, ADR out of range to four; the held input register emits one
// word per cycle, and o_busy stays high until the cycle of the final word,
// so the next request can be taken on that same edge.
// The address math is three parallel adders on the input register: target,
// byte displacement and page displacement, followed by the range check.
// Reset (synchronous, active low) drops any request in flight and clears
// the strobe; no clearing pass is needed.
module aarch64_pc_relative_relocator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [a64pcr_pkg::WordW-1:0]  i_instr_word,
    input  logic [a64pcr_pkg::AddrW-1:0]  i_source_pc,
    input  logic [a64pcr_pkg::AddrW-1:0]  i_dest_pc,
    output logic                          o_valid,
    output logic [a64pcr_pkg::WordW-1:0]  o_out_word,
    output logic                          o_last_word,
    output logic                          o_range_fail,
    output logic [a64pcr_pkg::ClsW-1:0]   o_instr_class
);
    import a64pcr_pkg::*;

    // input register: word, source pc, and the precomputed pc differences
    logic              r_in_valid;
    logic [WordW-1:0]  r_word;
    logic [AddrW-1:0]  r_src;
    logic [AddrW-1:0]  r_diff;
    logic [PageW-1:0]  r_pdiff;
    logic [IdxW-1:0]   r_idx;

    // result register
    logic              r_valid;
    logic [WordW-1:0]  r_out_word;
    logic              r_last;
    logic              r_fail;
    logic [ClsW-1:0]   r_cls;

    logic              accept;
    logic              at_last;
    t_cls              cls;
    logic [AddrW-1:0]  off;
    logic [AddrW-1:0]  tgt;
    logic [AddrW-1:0]  disp;
    logic [PageW-1:0]  pdisp;
    logic [PageW-1:0]  page_off;
    logic              fit;
    logic [IdxW-1:0]   last_idx;
    logic [4:0]        mov_rd;
    logic [WordW-1:0]  reenc;
    logic [WordW-1:0]  cur_word;
    logic              cur_fail;

    // Classify in priority order: BL, B, B.cond, CBZ, TBZ, ADR, ADRP, literal.
    always_comb begin
        if ((r_word & MaskBr) == OpBl) begin
            cls = ClsBl;
        end else if ((r_word & MaskBr) == OpB) begin
            cls = ClsB;
        end else if ((r_word & MaskBcond) == OpBcond) begin
            cls = ClsBcond;
        end else if ((r_word & MaskCb) == OpCbz) begin
            cls = ClsCbz;
        end else if ((r_word & MaskCb) == OpTbz) begin
            cls = ClsTbz;
        end else if ((r_word & MaskAdr) == OpAdr) begin
            cls = ClsAdr;
        end else if ((r_word & MaskAdr) == OpAdrp) begin
            cls = ClsAdrp;
        end else if ((r_word & MaskLit) == OpLit) begin
            cls = ClsLit;
        end else begin
            cls = ClsOther;
        end
    end

    // Select the sign-extended offset encoded in the word (in pages for ADRP).
    always_comb begin
        case (cls)
            ClsBl, ClsB: begin
                off = {{38{r_word[25]}}, r_word[25:0]} <<< 2;
            end
            ClsTbz: begin
                off = {{48{r_word[18]}}, r_word[18:5], 2'b00};
            end
            ClsAdr, ClsAdrp: begin
                off = {{43{r_word[23]}}, r_word[23:5], r_word[30:29]};
            end
            default: begin
                off = {{43{r_word[23]}}, r_word[23:5], 2'b00};
            end
        endcase
    end

    assign page_off = {{31{r_word[23]}}, r_word[23:5], r_word[30:29]};
    assign tgt      = r_src + off;
    assign disp     = r_diff + off;
    assign pdisp    = r_pdiff + page_off;

    // Range check: the displacement must fit its signed field and, for
    // word-scaled fields, land on a word boundary.
    always_comb begin
        case (cls)
            ClsTbz: begin
                fit = (r_diff[1:0] == 2'b00)
                    && ((&disp[AddrW-1:15]) || !(|disp[AddrW-1:15]));
            end
            ClsAdr: begin
                fit = (&disp[AddrW-1:20]) || !(|disp[AddrW-1:20]);
            end
            ClsAdrp: begin
                fit = (&pdisp[PageW-1:20]) || !(|pdisp[PageW-1:20]);
            end
            default: begin
                fit = (r_diff[1:0] == 2'b00)
                    && ((&disp[AddrW-1:20]) || !(|disp[AddrW-1:20]));
            end
        endcase
    end

    // Re-encoded single word and the word count of this request.
    always_comb begin
        reenc    = r_word;
        last_idx = LastOne;
        mov_rd   = ScratchReg;
        case (cls)
            ClsBl, ClsB: begin
                last_idx = LastBr5;
            end
            ClsBcond, ClsCbz, ClsLit: begin
                reenc = (r_word & KeepImm19) | {8'd0, disp[20:2], 5'd0};
            end
            ClsTbz: begin
                reenc = (r_word & KeepImm14) | {13'd0, disp[15:2], 5'd0};
            end
            ClsAdr: begin
                reenc  = (r_word & KeepAdr)
                       | {1'b0, disp[1:0], 5'd0, disp[20:2], 5'd0};
                mov_rd = r_word[4:0];
                if (!fit) begin
                    last_idx = LastMov4;
                end
            end
            ClsAdrp: begin
                reenc = (r_word & KeepAdr)
                      | {1'b0, pdisp[1:0], 5'd0, pdisp[20:2], 5'd0};
            end
            default: begin
                reenc = r_word;
            end
        endcase
    end

    // Pick the word for the current step of the request.
    always_comb begin
        cur_fail = 1'b0;
        if (last_idx == LastOne) begin
            // keep the original on an out-of-range displacement
            if (cls == ClsOther) begin
                cur_word = r_word;
            end else if (fit) begin
                cur_word = reenc;
            end else begin
                cur_word = r_word;
                cur_fail = 1'b1;
            end
        end else begin
            case (r_idx)
                3'd0:    cur_word = MovzHw0 | {11'd0, tgt[15:0], mov_rd};
                3'd1:    cur_word = MovkHw1 | {11'd0, tgt[31:16], mov_rd};
                3'd2:    cur_word = MovkHw2 | {11'd0, tgt[47:32], mov_rd};
                3'd3:    cur_word = MovkHw3 | {11'd0, tgt[63:48], mov_rd};
                default: cur_word = (cls == ClsBl) ? BlrX17 : BrX17;
            endcase
        end
    end

    assign at_last = (r_idx == last_idx);
    assign o_busy  = r_in_valid && !at_last;
    assign accept  = i_start && !o_busy;

    // Hold the request while its words step out; load a new one on accept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_idx      <= '0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
            r_idx      <= '0;
        end else if (r_in_valid) begin
            if (at_last) begin
                r_in_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word  <= i_instr_word;
            r_src   <= i_source_pc;
            r_diff  <= i_source_pc - i_dest_pc;
            r_pdiff <= i_source_pc[AddrW-1:12] - i_dest_pc[AddrW-1:12];
        end
    end

    // Result register: strobe one word per cycle while a request is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_out_word <= cur_word;
            r_last     <= at_last;
            r_fail     <= cur_fail;
            r_cls      <= cls;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_word    = r_out_word;
    assign o_last_word   = r_last;
    assign o_range_fail  = r_fail;
    assign o_instr_class = r_cls;

endmodule

### test/tb_aarch64_pc_relative_relocator_core.sv
`timescale 1ns / 1ps

module tb_aarch64_pc_relative_relocator_core;

    import a64pcr_pkg::*;

    // Run-away guard: about 370 requests, each at worst with the longest gap and a
    // five-word expansion, stay far below this bound.
    localparam int CycleLimit  = 200000;
    localparam int DrainCycles = 8;
    localparam int RandomBursts = 10;
    localparam int BurstLen     = 35;

    // One emitted word as the block should present it.
    typedef struct packed {
        logic [WordW-1:0] word;
        logic             last;
        logic             fail;
        t_cls             cls;
    } t_reloc_word;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    logic [WordW-1:0]    i_instr_word;
    logic [AddrW-1:0]    i_source_pc;
    logic [AddrW-1:0]    i_dest_pc;
    logic                o_valid;
    logic [WordW-1:0]    o_out_word;
    logic                o_last_word;
    logic                o_range_fail;
    logic [ClsW-1:0]     o_instr_class;

    // Words still owed by the block, oldest first.
    t_reloc_word pending_words[$];
    t_reloc_word next_word;
    int          fail_count;
    int          cycle_count;

    aarch64_pc_relative_relocator_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_instr_word  (i_instr_word),
        .i_source_pc   (i_source_pc),
        .i_dest_pc     (i_dest_pc),
        .o_valid       (o_valid),
        .o_out_word    (o_out_word),
        .o_last_word   (o_last_word),
        .o_range_fail  (o_range_fail),
        .o_instr_class (o_instr_class)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Relocation predictor
    // ------------------------------------------------------------------

    // Sign-extend the low 'bits' bits of v to 64 bits.
    function automatic logic [AddrW-1:0] sext_bits(logic [AddrW-1:0] v, int bits);
        logic [AddrW-1:0] msb_mask;
        msb_mask = 64'd1 << (bits - 1);
        v = v & ((64'd1 << bits) - 64'd1);
        return (v ^ msb_mask) - msb_mask;
    endfunction

    // Check that the wrapped displacement d, read as signed, fits a signed
    // immediate of 'bits' bits scaled by 2^shift with the low bits clear.
    function automatic bit disp_fits(logic [AddrW-1:0] d, int bits, int shift);
        int span;
        span = bits + shift;
        if ((d & ((64'd1 << shift) - 64'd1)) != 64'd0) return 1'b0;
        return (d + (64'd1 << (span - 1))) < (64'd1 << span);
    endfunction

    function automatic void push_word(logic [WordW-1:0] word, logic last, logic fail,
                                      t_cls cls);
        t_reloc_word entry;
        entry.word = word;
        entry.last = last;
        entry.fail = fail;
        entry.cls  = cls;
        pending_words.insert(pending_words.size(), entry);
    endfunction

    // Build a 64-bit absolute value in rd with MOVZ and three MOVKs.
    function automatic void push_mov4(logic [AddrW-1:0] v, logic [4:0] rd, logic last_on_4,
                                      t_cls cls);
        push_word(MovzHw0 | {11'd0, v[15:0], 5'd0} | {27'd0, rd}, 1'b0, 1'b0, cls);
        push_word(MovkHw1 | {11'd0, v[31:16], 5'd0} | {27'd0, rd}, 1'b0, 1'b0, cls);
        push_word(MovkHw2 | {11'd0, v[47:32], 5'd0} | {27'd0, rd}, 1'b0, 1'b0, cls);
        push_word(MovkHw3 | {11'd0, v[63:48], 5'd0} | {27'd0, rd}, last_on_4, 1'b0, cls);
    endfunction

    // Queue every word the block must emit for one request.
    function automatic void predict_relocation(logic [WordW-1:0] w, logic [AddrW-1:0] src,
                                               logic [AddrW-1:0] dst);
        t_cls             cls;
        logic [AddrW-1:0] tgt;
        logic [AddrW-1:0] d;
        logic [AddrW-1:0] off;
        logic [20:0]      imm;
        if ((w & MaskBr) == OpBl || (w & MaskBr) == OpB) begin
            // Unconditional branches always expand to an absolute jump via x17.
            cls = ((w & MaskBr) == OpBl) ? ClsBl : ClsB;
            tgt = src + (sext_bits({38'd0, w[25:0]}, 26) << 2);
            push_mov4(tgt, ScratchReg, 1'b0, cls);
            push_word((cls == ClsBl) ? BlrX17 : BrX17, 1'b1, 1'b0, cls);
        end else if ((w & MaskBcond) == OpBcond || (w & MaskCb) == OpCbz) begin
            cls = ((w & MaskBcond) == OpBcond) ? ClsBcond : ClsCbz;
            tgt = src + (sext_bits({45'd0, w[23:5]}, 19) << 2);
            d = tgt - dst;
            if (disp_fits(d, 19, 2)) begin
                push_word((w & KeepImm19) | {8'd0, d[20:2], 5'd0}, 1'b1, 1'b0, cls);
            end else begin
                push_word(w, 1'b1, 1'b1, cls);
            end
        end else if ((w & MaskCb) == OpTbz) begin
            tgt = src + (sext_bits({50'd0, w[18:5]}, 14) << 2);
            d = tgt - dst;
            if (disp_fits(d, 14, 2)) begin
                push_word((w & KeepImm14) | {13'd0, d[15:2], 5'd0}, 1'b1, 1'b0, ClsTbz);
            end else begin
                push_word(w, 1'b1, 1'b1, ClsTbz);
            end
        end else if ((w & MaskAdr) == OpAdr || (w & MaskAdr) == OpAdrp) begin
            off = sext_bits({43'd0, w[23:5], w[30:29]}, 21);
            if ((w & MaskAdr) == OpAdrp) begin
                tgt = (src & ~64'hfff) + (off << 12);
                d = (tgt & ~64'hfff) - (dst & ~64'hfff);
                if (disp_fits(d, 21, 12)) begin
                    imm = d[32:12];
                    push_word((w & KeepAdr) | {1'b0, imm[1:0], 5'd0, imm[20:2], 5'd0},
                              1'b1, 1'b0, ClsAdrp);
                end else begin
                    push_word(w, 1'b1, 1'b1, ClsAdrp);
                end
            end else begin
                tgt = src + off;
                d = tgt - dst;
                if (disp_fits(d, 21, 0)) begin
                    imm = d[20:0];
                    push_word((w & KeepAdr) | {1'b0, imm[1:0], 5'd0, imm[20:2], 5'd0},
                              1'b1, 1'b0, ClsAdr);
                end else begin
                    // Out of reach: materialize the target in ADR's own register.
                    push_mov4(tgt, w[4:0], 1'b1, ClsAdr);
                end
            end
        end else if ((w & MaskLit) == OpLit) begin
            tgt = src + (sext_bits({45'd0, w[23:5]}, 19) << 2);
            d = tgt - dst;
            if (disp_fits(d, 19, 2)) begin
                push_word((w & KeepImm19) | {8'd0, d[20:2], 5'd0}, 1'b1, 1'b0, ClsLit);
            end else begin
                push_word(w, 1'b1, 1'b1, ClsLit);
            end
        end else begin
            push_word(w, 1'b1, 1'b0, ClsOther);
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------

    // Idle for the requested gap, then present the request at the falling edge and
    // hold it until a rising edge finds the block not busy. With no gap the
    // start strobe simply stays high for the next request.
    task automatic send_request(input logic [WordW-1:0] word, input logic [AddrW-1:0] src,
                                input logic [AddrW-1:0] dst, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_start      <= 1'b1;
        i_instr_word <= word;
        i_source_pc  <= src;
        i_dest_pc    <= dst;
        do @(posedge i_clk); while (o_busy);
        predict_relocation(word, src, dst);
    endtask

    function automatic int pick_gap();
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [AddrW-1:0] pick_source();
        case ($urandom_range(0, 7))
            0:       return {$urandom, $urandom} & 64'hffff;
            1:       return ~({$urandom, $urandom} & 64'hffff);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Place the destination near the source most of the time so that the
    // short forms re-encode; otherwise push it far or off alignment.
    function automatic logic [AddrW-1:0] pick_dest(logic [AddrW-1:0] src);
        logic [AddrW-1:0] off;
        logic [1:0]       top;
        int               mag;
        mag = $urandom_range(2, 34);
        top = 2'($urandom_range(0, 3));
        off = {$urandom, $urandom} & ((64'd1 << mag) - 64'd1);
        if ($urandom_range(0, 1) == 1) off = -off;
        case ($urandom_range(0, 5))
            0:       return src;
            1, 2:    return src + (off & ~64'd3);
            3:       return src + off;
            4:       return {$urandom, $urandom};
            default: return src + (off & ~64'd3) + {top, 62'd0};
        endcase
    endfunction

    // Build a well-formed word of a random class with random operand bits.
    function automatic logic [WordW-1:0] pick_word();
        logic [WordW-1:0] r;
        r = $urandom;
        case (t_cls'($urandom_range(0, 8)))
            ClsBl:    return OpBl    | (r & 32'h03ffffff);
            ClsB:     return OpB     | (r & 32'h03ffffff);
            ClsBcond: return OpBcond | (r & 32'h00ffffef);
            ClsCbz:   return OpCbz   | (r & 32'h81ffffff);
            ClsTbz:   return OpTbz   | (r & 32'h81ffffff);
            ClsAdr:   return OpAdr   | (r & 32'h60ffffff);
            ClsAdrp:  return OpAdrp  | (r & 32'h60ffffff);
            ClsLit:   return OpLit   | (r & 32'hc4ffffff);
            default:  return r;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobed word must match the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_words.size() == 0) begin
                $error("unexpected result word %h", o_out_word);
                fail_count++;
            end else begin
                next_word = pending_words.pop_front();
                if (o_out_word !== next_word.word) begin
                    $error("out_word: expected %h, actual %h", next_word.word, o_out_word);
                    fail_count++;
                end
                if (o_last_word !== next_word.last) begin
                    $error("last_word: expected %b, actual %b", next_word.last, o_last_word);
                    fail_count++;
                end
                if (o_range_fail !== next_word.fail) begin
                    $error("range_fail: expected %b, actual %b", next_word.fail,
                           o_range_fail);
                    fail_count++;
                end
                if (o_instr_class !== next_word.cls) begin
                    $error("instr_class: expected %0d, actual %0d", next_word.cls,
                           o_instr_class);
                    fail_count++;
                end
            end
        end
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // BL and B with imm26 at its maximum, minimum, zero and minus one; one target wraps.
    task automatic test_branch_expansion();
        send_request(OpBl | 32'h01ffffff, 64'd0, 64'h1000, pick_gap());
        send_request(OpBl | 32'h02000000, 64'd0, 64'd0, pick_gap());
        send_request(OpB, {64{1'b1}}, 64'h8000_0000_0000_0000, pick_gap());
        send_request(OpB | 32'h03ffffff, 64'h0000_7fff_0000_0004, 64'd4, pick_gap());
    endtask

    // B.cond, CBZ and TBZ: in range, far, misaligned, and both edges of imm14.
    task automatic test_short_branch_reencode();
        send_request(OpBcond | 32'h0000_0020, 64'h1000, 64'h1000, pick_gap());
        send_request(OpBcond | 32'h00ff_ffef, 64'h1000, 64'h0100_1000, pick_gap());
        send_request(32'hb4ff_ffe5, 64'h4_0000, 64'h4_0000, pick_gap());
        send_request(OpCbz | 32'h0000_0043, 64'h4_0000, 64'h4_0002, pick_gap());
        // imm14 = 2: target is source + 8; hit the signed minimum, then one past the max
        send_request(OpTbz | 32'h0000_0040, 64'h10_0000, 64'h10_8008, pick_gap());
        send_request(OpTbz | 32'h0000_0040, 64'h10_0000, 64'h0f_8008, pick_gap());
    endtask

    // ADR re-encode, ADR fallback to four MOVs, byte offsets, ADRP in and out of range.
    task automatic test_adr_adrp();
        send_request(OpAdr | 32'h6000_0025, 64'h2000, 64'h2000, pick_gap());
        send_request(OpAdr | 32'h00ff_ffff, 64'h2000, 64'h0000_0100_0000_2000, pick_gap());
        send_request(OpAdr | 32'h2000_0003, 64'h2000, 64'h2001, pick_gap());
        send_request(OpAdrp | 32'h6000_0088, 64'h1234_5678, 64'h1234_0000, pick_gap());
        send_request(OpAdrp | 32'h0000_0001, 64'h1234_5678, 64'h0000_0100_1234_5678,
                     pick_gap());
    endtask

    // Integer, FP/SIMD and prefetch literal forms, plus a misaligned destination.
    task automatic test_literal_loads();
        send_request(32'h5800_0040, 64'h8000, 64'h8000, pick_gap());
        send_request(32'h9c00_0005, 64'h8000, 64'h9000, pick_gap());
        send_request(32'hd8ff_ffe0, 64'h8000, 64'h7000, pick_gap());
        send_request(32'h1800_0021, 64'h8000, 64'h8001, pick_gap());
    endtask

    // Zero word, all-ones word and a B.cond look-alike that must fall through.
    task automatic test_passthrough_and_edges();
        send_request(32'd0, 64'd0, 64'd0, pick_gap());
        send_request({32{1'b1}}, {64{1'b1}}, {64{1'b1}}, pick_gap());
        send_request(OpBcond | 32'h0000_0010, 64'h100, 64'h100, pick_gap());
    endtask

    // Bursts of random requests; some bursts run back to back with no idling.
    task automatic test_random_traffic();
        logic [AddrW-1:0] src;
        bit               no_idle;
        for (int b = 0; b < RandomBursts; b++) begin
            no_idle = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < BurstLen; n++) begin
                src = pick_source();
                send_request(pick_word(), src, pick_dest(src), no_idle ? 0 : pick_gap());
            end
        end
    endtask

    initial begin
        fail_count   = 0;
        cycle_count  = 0;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_instr_word = '0;
        i_source_pc  = '0;
        i_dest_pc    = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_passthrough_and_edges();
        test_branch_expansion();
        test_short_branch_reencode();
        test_adr_adrp();
        test_literal_loads();
        test_random_traffic();

        // Drop the strobe, drain the owed words, then allow for latency.
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/a64pcr_pkg.sv
rtl/aarch64_pc_relative_relocator_core.sv
test/tb_aarch64_pc_relative_relocator_core.sv
